>>> rtl/core/ssort_pkg.sv
// Shared types and constants of the Shell sorter: record layout, sizes,
// controller states, datapath operations and the status word. No dependencies.
`default_nettype none

package ssort_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int KEY_W     = 16;
   localparam int PAY_W     = 16;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int GAP_W     = CNT_W + 2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } rec_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_GAP_UP,
      ST_GAP_DIV,
      ST_PASS_START,
      ST_READ_I,
      ST_HOLD,
      ST_COMPARE,
      ST_PLACE,
      ST_PASS_DONE,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_SEND
   } state_type;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_GAP_UP,
      OP_GAP_DIV,
      OP_PASS_START,
      OP_READ_I,
      OP_HOLD,
      OP_COMPARE,
      OP_PLACE,
      OP_PASS_DONE,
      OP_OUT_READ,
      OP_OUT_LOAD,
      OP_OUT_SEND
   } op_type;

   typedef struct packed {
      logic gap_up_done;
      logic div_hit;
      logic gap_ge_n;
      logic gap_is_one;
      logic greater;
      logic j_break;
      logic i_end;
      logic out_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/ssort_ctrl.sv
// Controller state machine of the Shell sorter. It sequences loading, gap
// computation, the gapped insertion passes and the output phase. Uses ssort_pkg.
`default_nettype none

module ssort_ctrl
   import ssort_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last_item,
   output logic            req_stall,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output op_type          op
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_LOAD;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            op        = OP_LOAD;
            req_stall = 1'b0;
            if (req_valid && req_last_item) begin
               state_in = ST_GAP_UP;
            end
         end
         ST_GAP_UP: begin
            op = OP_GAP_UP;
            if (status.gap_up_done) begin
               state_in = ST_GAP_DIV;
            end
         end
         ST_GAP_DIV: begin
            op = OP_GAP_DIV;
            if (status.div_hit) begin
               state_in = ST_PASS_START;
            end
         end
         ST_PASS_START: begin
            op = OP_PASS_START;
            if (status.gap_ge_n) begin
               state_in = ST_PASS_DONE;
            end else begin
               state_in = ST_READ_I;
            end
         end
         ST_READ_I: begin
            op       = OP_READ_I;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            op       = OP_HOLD;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            op = OP_COMPARE;
            if (status.greater) begin
               if (status.j_break) begin
                  state_in = ST_PLACE;
               end
            end else if (status.i_end) begin
               state_in = ST_PASS_DONE;
            end else begin
               state_in = ST_READ_I;
            end
         end
         ST_PLACE: begin
            op = OP_PLACE;
            if (status.i_end) begin
               state_in = ST_PASS_DONE;
            end else begin
               state_in = ST_READ_I;
            end
         end
         ST_PASS_DONE: begin
            op = OP_PASS_DONE;
            if (status.gap_is_one) begin
               state_in = ST_OUT_READ;
            end else begin
               state_in = ST_GAP_DIV;
            end
         end
         ST_OUT_READ: begin
            op       = OP_OUT_READ;
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            op       = OP_OUT_LOAD;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            op = OP_OUT_SEND;
            if (!rsp_stall) begin
               if (status.out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/ssort_dp.sv
// Datapath of the Shell sorter: record memory, count, gap, index registers,
// held record and the output register. Driven by ssort_ctrl; uses ssort_pkg.
`default_nettype none

module ssort_dp
   import ssort_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire op_type           op,
   output status_type            status,
   input  wire logic             req_valid,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [PAY_W-1:0] req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [KEY_W-1:0]      rsp_sorted_key,
   output logic [PAY_W-1:0]      rsp_sorted_payload,
   output logic                  rsp_last_result,
   output logic                  rsp_overflow
);

   rec_type mem [MAX_ITEMS];

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic [GAP_W-1:0]  t_ff, t_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rec_type           held_ff, held_in;
   rec_type           rdata_ff;
   rec_type           out_rec_ff, out_rec_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              we;
   logic [ADDR_W-1:0] wa;
   rec_type           wd;
   logic [ADDR_W-1:0] ra;

   logic [GAP_W-1:0]  gap3p1;
   logic [GAP_W-1:0]  t3p1;
   logic [ADDR_W-1:0] gap_a;
   logic [ADDR_W-1:0] jn;

   assign gap3p1 = (gap_ff << 1) + gap_ff + GAP_W'(1);
   assign t3p1   = (t_ff << 1) + t_ff + GAP_W'(1);
   assign gap_a  = gap_ff[ADDR_W-1:0];
   assign jn     = j_ff - gap_a;

   assign status.gap_up_done = gap3p1 >= GAP_W'(cnt_ff);
   assign status.div_hit     = t3p1 == gap_ff;
   assign status.gap_ge_n    = gap_ff >= GAP_W'(cnt_ff);
   assign status.gap_is_one  = gap_ff == GAP_W'(1);
   assign status.greater     = rdata_ff.key > held_ff.key;
   assign status.j_break     = jn < gap_a;
   assign status.i_end       = (CNT_W'(i_ff) + CNT_W'(1)) >= cnt_ff;
   assign status.out_last    = (CNT_W'(k_ff) + CNT_W'(1)) == cnt_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      gap_in       = gap_ff;
      t_in         = t_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      out_rec_in   = out_rec_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      we           = 1'b0;
      wa           = j_ff;
      wd           = held_ff;
      ra           = k_ff;
      unique case (op)
         OP_LOAD: begin
            gap_in = GAP_W'(1);
            wa     = cnt_ff[ADDR_W-1:0];
            wd     = '{key: req_key, payload: req_payload};
            if (req_valid) begin
               if (cnt_ff < CNT_W'(MAX_ITEMS)) begin
                  we     = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         OP_GAP_UP: begin
            gap_in = gap3p1;
            t_in   = GAP_W'(1);
         end
         OP_GAP_DIV: begin
            if (status.div_hit) begin
               gap_in = t_ff;
            end else begin
               t_in = t3p1;
            end
         end
         OP_PASS_START: begin
            i_in = gap_a;
         end
         OP_READ_I: begin
            ra = i_ff;
         end
         OP_HOLD: begin
            held_in = rdata_ff;
            j_in    = i_ff;
            ra      = i_ff - gap_a;
         end
         OP_COMPARE: begin
            we = 1'b1;
            if (status.greater) begin
               wd   = rdata_ff;
               j_in = jn;
               ra   = jn - gap_a;
            end else begin
               i_in = i_ff + ADDR_W'(1);
            end
         end
         OP_PLACE: begin
            we   = 1'b1;
            i_in = i_ff + ADDR_W'(1);
         end
         OP_PASS_DONE: begin
            t_in = GAP_W'(1);
            k_in = '0;
         end
         OP_OUT_READ: begin
            ra = k_ff;
         end
         OP_OUT_LOAD: begin
            out_rec_in   = rdata_ff;
            out_last_in  = status.out_last;
            out_ovf_in   = ovf_ff;
            rsp_valid_in = 1'b1;
         end
         OP_OUT_SEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + ADDR_W'(1);
               if (status.out_last) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         gap_ff       <= GAP_W'(1);
         t_ff         <= GAP_W'(1);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         gap_ff       <= gap_in;
         t_ff         <= t_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      out_rec_ff  <= out_rec_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[ra];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_key     = out_rec_ff.key;
   assign rsp_sorted_payload = out_rec_ff.payload;
   assign rsp_last_result    = out_last_ff;
   assign rsp_overflow       = out_ovf_ff;

   a_valid_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> op == OP_OUT_SEND)
      else $error("Result valid outside the output phase.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ITEMS))
      else $error("Record count above capacity.");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      op == OP_COMPARE |-> (j_ff >= gap_a) && (GAP_W'(cnt_ff) > gap_ff))
      else $error("Insertion index below the gap.");

   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      gap_ff != '0)
      else $error("Gap reached zero.");

endmodule

`default_nettype wire

>>> rtl/core/shell_sorter.sv
// Top level of the Shell sorter: joins the controller ssort_ctrl and the
// datapath ssort_dp. Uses ssort_pkg.
//
//   Channel  Prefix  Direction  Contents
//   request  req_    in         key, payload, last_item
//   result   rsp_    out        sorted_key, sorted_payload, last_result, overflow
//
// Loading takes one cycle per record; records are not taken during sort and output.
// Sort: the gap is grown step by step and, before each pass, divided down step by
// step; each pass visits every index from the gap upward and shifts records one at
// a time, all bound by the single read port of the record memory.
// Output: each record is read, loaded into the output register and sent; a stall holds the result.
// Synchronous reset returns to loading with an empty store.
`default_nettype none

module shell_sorter
   import ssort_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [PAY_W-1:0] req_payload,
   input  wire logic             req_last_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [KEY_W-1:0]      rsp_sorted_key,
   output logic [PAY_W-1:0]      rsp_sorted_payload,
   output logic                  rsp_last_result,
   output logic                  rsp_overflow
);

   op_type     op;
   status_type status;

   ssort_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .op            (op)
   );

   ssort_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .req_valid          (req_valid),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_key     (rsp_sorted_key),
      .rsp_sorted_payload (rsp_sorted_payload),
      .rsp_last_result    (rsp_last_result),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire
